/* src/crc32c_zs_pkg.sv */
// ----------------------------------------------------------------------------
// crc32c_zs_pkg
// Types, constants and GF(2) helpers for the CRC-32C zero-byte shift unit.
// ----------------------------------------------------------------------------
package crc32c_zs_pkg;

    localparam int          CRC_BITS         = 32;
    localparam int          BYTE_LANES       = 4;
    localparam int          LANE_ENTRIES     = 256;
    localparam int          LANE_ADDR_BITS   = 8;
    localparam int          COL_BITS         = 5;
    localparam int          PRE_SQUARES      = 3;
    localparam int          LENGTH_BITS_DEF  = 24;
    localparam logic [31:0] CRC32C_POLY_REFL = 32'h82F6_3B78;
    localparam logic [31:0] RESET_SHIFT_BYTES = 32'd1024;

    typedef logic [CRC_BITS-1:0]               t_word;
    typedef logic [CRC_BITS-1:0][CRC_BITS-1:0] t_mat;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOAD   = 6'b000010,
        S_SQ     = 6'b000100,
        S_CH     = 6'b001000,
        S_COPY   = 6'b010000,
        S_FILL   = 6'b100000
    } t_state;

    function automatic t_word gf2_apply(input t_mat m, input t_word v);
        t_word acc;
        acc = '0;
        for (int k = 0; k < CRC_BITS; k++) begin
            if (v[k]) begin
                acc = acc ^ m[k];
            end
        end
        return acc;
    endfunction

    function automatic t_mat one_zero_bit();
        t_mat m;
        m[0] = CRC32C_POLY_REFL;
        for (int k = 1; k < CRC_BITS; k++) begin
            m[k] = t_word'(1) << (k - 1);
        end
        return m;
    endfunction

    function automatic t_mat identity();
        t_mat m;
        for (int k = 0; k < CRC_BITS; k++) begin
            m[k] = t_word'(1) << k;
        end
        return m;
    endfunction

endpackage

/* src/crc32c_zero_byte_shift_unit.sv */
// ----------------------------------------------------------------------------
// crc32c_zero_byte_shift_unit
// Advances a reflected CRC-32C value past a programmed number of zero bytes.
// ----------------------------------------------------------------------------
// Items enter one per cycle whenever o_busy is low; each result appears on
// o_crc_shifted with o_valid high for exactly one cycle, after a registered
// table read and a registered XOR of the four lanes. The receiver cannot
// stall the output. After reset and after every write of the length register
// the unit is busy while it rebuilds its operator and refills its four
// 256-entry lookup memories: each matrix square or multiply builds one column
// a cycle and then copies the result, up to 2 + 2*LENGTH_BITS of them, then
// the table fill writes all 256 entries of each memory.
module crc32c_zero_byte_shift_unit #(
    parameter int LENGTH_BITS = crc32c_zs_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [31:0]            i_crc_in,
    output logic                   o_valid,
    output logic [31:0]            o_crc_shifted,
    input  logic                   i_cfg_we,
    input  logic [LENGTH_BITS-1:0] i_cfg_wdata
);
    import crc32c_zs_pkg::*;

    t_state                   r_state, n_state;
    logic [LENGTH_BITS-1:0]   r_len, n_len;
    logic [1:0]               r_pre, n_pre;
    logic                     r_is_ch, n_is_ch;
    logic [COL_BITS-1:0]      r_col;
    logic [LANE_ADDR_BITS-1:0] r_fill;
    t_mat                     r_b, r_acc, r_t;
    logic                     r_v1, r_v2;
    t_word                    r_crc;
    t_word                    rd_data [BYTE_LANES];
    logic                     accept;
    logic                     col_last;
    t_state                   dec_state;
    logic [LENGTH_BITS-1:0]   dec_len;
    logic [LENGTH_BITS-1:0]   len_sh;
    logic                     dec_ch;
    t_word                    col_val;

    assign accept   = i_start && !o_busy;
    assign o_busy   = (r_state != S_IDLE);
    assign col_last = (r_col == COL_BITS'(CRC_BITS - 1));
    assign len_sh   = r_len >> 1;
    assign col_val  = gf2_apply(r_b, r_is_ch ? r_acc[r_col] : r_b[r_col]);

    // decide next step of square-and-multiply from the remaining length
    always_comb begin
        dec_len   = r_len;
        dec_ch    = 1'b0;
        dec_state = S_FILL;
        if (r_len == '0) begin
            dec_state = S_FILL;
        end else if (r_len[0]) begin
            dec_state = S_CH;
            dec_ch    = 1'b1;
        end else begin
            dec_len   = len_sh;
            dec_state = (len_sh == '0) ? S_FILL : S_SQ;
        end
    end

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_pre   = r_pre;
        n_is_ch = r_is_ch;
        unique case (r_state)
            S_IDLE: begin
            end
            S_LOAD: begin
                n_state = S_SQ;
                n_pre   = 2'(PRE_SQUARES);
                n_is_ch = 1'b0;
            end
            S_SQ, S_CH: begin
                if (col_last) begin
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                if (r_is_ch) begin
                    n_len   = len_sh;
                    n_is_ch = 1'b0;
                    n_state = (len_sh == '0) ? S_FILL : S_SQ;
                end else if (r_pre > 2'd1) begin
                    n_pre   = r_pre - 2'd1;
                    n_state = S_SQ;
                end else begin
                    n_pre   = '0;
                    n_len   = dec_len;
                    n_is_ch = dec_ch;
                    n_state = dec_state;
                end
            end
            S_FILL: begin
                if (r_fill == LANE_ADDR_BITS'(LANE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_we) begin
            n_state = S_LOAD;
            n_len   = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_len   <= LENGTH_BITS'(RESET_SHIFT_BYTES);
            r_pre   <= '0;
            r_is_ch <= 1'b0;
            r_col   <= '0;
            r_fill  <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_pre   <= n_pre;
            r_is_ch <= n_is_ch;
            r_col   <= (r_state == S_SQ || r_state == S_CH) ? r_col + 1'b1 : '0;
            r_fill  <= (r_state == S_FILL) ? r_fill + 1'b1 : '0;
            r_v1    <= accept;
            r_v2    <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_b   <= one_zero_bit();
            r_acc <= identity();
        end
        if (r_state == S_SQ || r_state == S_CH) begin
            r_t[r_col] <= col_val;
        end
        if (r_state == S_COPY) begin
            if (r_is_ch) begin
                r_acc <= r_t;
            end else begin
                r_b <= r_t;
            end
        end
    end

    for (genvar l = 0; l < BYTE_LANES; l++) begin : g_lane
        t_word mem [LANE_ENTRIES];
        always_ff @(posedge i_clk) begin
            if (r_state == S_FILL) begin
                mem[r_fill] <= gf2_apply(r_acc, t_word'(r_fill) << (8 * l));
            end
            rd_data[l] <= mem[i_crc_in[8*l +: 8]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= rd_data[0] ^ rd_data[1] ^ rd_data[2] ^ rd_data[3];
    end

    assign o_valid       = r_v2;
    assign o_crc_shifted = r_crc;

    a_valid_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 2))
        else $error("result without accepted item");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");

    a_idle_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> $past(r_state == S_FILL))
        else $error("left rebuild without table fill");

endmodule

/* tb/crc32c_zs_checker.sv */
// ----------------------------------------------------------------------------
// crc32c_zs_checker
// Watches the item, result and length-register ports of the zero-byte shift
// unit. It keeps its own operator matrix, rebuilt on reset and on each
// length write, predicts every shifted CRC and compares it in order.
// ----------------------------------------------------------------------------
module crc32c_zs_checker #(
    parameter int LENGTH_BITS = crc32c_zs_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  logic [31:0]            i_crc_in,
    input  logic                   i_valid,
    input  logic [31:0]            i_crc_shifted,
    input  logic                   i_cfg_we,
    input  logic [LENGTH_BITS-1:0] i_cfg_wdata,
    output int                     o_pending,
    output int                     o_errors
);
    import crc32c_zs_pkg::*;

    t_mat        shift_op;
    logic [31:0] shifted_crc_q[$];

    function automatic t_word op_apply(input t_mat m, input t_word v);
        t_word r;
        r = '0;
        for (int k = 0; k < 32; k++) begin
            if (v[k]) begin
                r ^= m[k];
            end
        end
        return r;
    endfunction

    function automatic t_mat op_square(input t_mat m);
        t_mat r;
        for (int k = 0; k < 32; k++) begin
            r[k] = op_apply(m, m[k]);
        end
        return r;
    endfunction

    function automatic t_mat zero_shift_op(input logic [31:0] nbytes);
        t_mat        bit_op;
        t_mat        step;
        t_mat        acc;
        logic [31:0] n;
        n = nbytes;
        bit_op[0] = CRC32C_POLY_REFL;
        for (int k = 1; k < 32; k++) begin
            bit_op[k] = 32'd1 << (k - 1);
        end
        step = op_square(op_square(op_square(bit_op)));
        for (int k = 0; k < 32; k++) begin
            acc[k] = 32'd1 << k;
        end
        while (n != 0) begin
            if (n[0]) begin
                for (int k = 0; k < 32; k++) begin
                    acc[k] = op_apply(step, acc[k]);
                end
            end
            n = n >> 1;
            if (n != 0) begin
                step = op_square(step);
            end
        end
        return acc;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shift_op = zero_shift_op(RESET_SHIFT_BYTES);
            shifted_crc_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_valid) begin
                if (shifted_crc_q.size() == 0) begin
                    if (o_errors < 10) begin
                        $display("unexpected result %h", i_crc_shifted);
                    end
                    o_errors <= o_errors + 1;
                end else if (shifted_crc_q[0] !== i_crc_shifted) begin
                    if (o_errors < 10) begin
                        $display("crc_shifted mismatch: expected %h actual %h",
                                 shifted_crc_q[0], i_crc_shifted);
                    end
                    o_errors <= o_errors + 1;
                    void'(shifted_crc_q.pop_front());
                end else begin
                    void'(shifted_crc_q.pop_front());
                end
            end
            if (i_start && !i_busy) begin
                shifted_crc_q.push_back(op_apply(shift_op, i_crc_in));
            end
            if (i_cfg_we) begin
                shift_op = zero_shift_op(32'(i_cfg_wdata));
            end
            o_pending <= shifted_crc_q.size();
        end
    end
endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the CRC-32C zero-byte shift unit: directed and random CRCs
// across several shift lengths, with random sender gaps, and the verdict.
// ----------------------------------------------------------------------------
module tb;
    localparam int LB = crc32c_zs_pkg::LENGTH_BITS_DEF;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_start;
    logic          o_busy;
    logic [31:0]   i_crc_in;
    logic          o_valid;
    logic [31:0]   o_crc_shifted;
    logic          i_cfg_we;
    logic [LB-1:0] i_cfg_wdata;
    int            pending;
    int            errors;

    crc32c_zero_byte_shift_unit #(.LENGTH_BITS(LB)) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_crc_in     (i_crc_in),
        .o_valid      (o_valid),
        .o_crc_shifted(o_crc_shifted),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    crc32c_zs_checker #(.LENGTH_BITS(LB)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_crc_in     (i_crc_in),
        .i_valid      (o_valid),
        .i_crc_shifted(o_crc_shifted),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_pending    (pending),
        .o_errors     (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_crc(input logic [31:0] crc, input bit gaps);
        logic b;
        if (gaps && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_start  <= 1'b1;
        i_crc_in <= crc;
        forever begin
            @(negedge i_clk);
            b = o_busy;
            @(posedge i_clk);
            if (!b) break;
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [LB-1:0] nbytes);
        logic b;
        drain();
        forever begin
            @(negedge i_clk);
            b = o_busy;
            @(posedge i_clk);
            if (!b) break;
        end
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= nbytes;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_crcs(input int n, input bit gaps);
        logic [31:0] v;
        for (int i = 0; i < n; i++) begin
            v = $urandom;
            if ($urandom_range(0, 7) == 0) v = 32'd1 << $urandom_range(0, 31);
            send_crc(v, gaps);
        end
    endtask

    logic [LB-1:0] lengths[8];

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_crc_in    = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_crc(32'h0000_0000, 1'b0);
        send_crc(32'hFFFF_FFFF, 1'b0);
        send_crc(32'hAAAA_AAAA, 1'b0);
        send_crc(32'h5555_5555, 1'b0);
        for (int k = 0; k < 32; k += 3) send_crc(32'd1 << k, 1'b0);
        send_crc(32'h8000_0000, 1'b0);
        random_crcs(100, 1'b1);

        lengths[0] = '0;
        lengths[1] = LB'(1);
        lengths[2] = '1;
        lengths[3] = LB'(2);
        lengths[4] = LB'($urandom);
        lengths[5] = LB'(1) << (LB - 1);
        lengths[6] = LB'($urandom_range(3, 5000));
        lengths[7] = LB'(1024);
        for (int p = 0; p < 8; p++) begin
            write_length(lengths[p]);
            send_crc(32'hFFFF_FFFF, 1'b0);
            send_crc(32'h0000_0001, 1'b0);
            random_crcs(100, p != 7);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
